[rtl/core/assert_macros.svh]
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// cons must hold in the same cycle as ante.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

[rtl/core/tppf_pkg.sv]
`default_nettype none

package tppf_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned PORT_W  = 16;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned CAUSE_W = 3;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [COUNT_W-1:0] ETH_HDR_LEN = 7'd14;
   localparam logic [COUNT_W-1:0] ETH_TYPE_HI = 7'd12;
   localparam logic [COUNT_W-1:0] ETH_TYPE_LO = 7'd13;
   localparam logic [COUNT_W-1:0] IP_PROTO_POS = 7'd23;
   localparam logic [COUNT_W-1:0] IP_MIN_END  = 7'd34;
   localparam logic [COUNT_W-1:0] TCP_HDR_LEN = 7'd20;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd127;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;

   localparam logic [PORT_W-1:0] PORT_A_RESET = 16'd1234;
   localparam logic [PORT_W-1:0] PORT_B_RESET = 16'd80;

   localparam logic [CSR_IDX_W-1:0] CSR_PORT_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PORT_B = 2'd1;

   localparam logic [CAUSE_W-1:0] CAUSE_MATCH     = 3'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_SHORT_ETH = 3'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_NOT_IPV4  = 3'd2;
   localparam logic [CAUSE_W-1:0] CAUSE_SHORT_IP  = 3'd3;
   localparam logic [CAUSE_W-1:0] CAUSE_NOT_TCP   = 3'd4;
   localparam logic [CAUSE_W-1:0] CAUSE_SHORT_TCP = 3'd5;
   localparam logic [CAUSE_W-1:0] CAUSE_MISMATCH  = 3'd6;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } beat_type;

endpackage

`default_nettype wire

[rtl/core/tcp_port_pair_packet_filter_top.sv]
// Channel | Direction | Handshake           | Payload
// req_    | in        | req_valid/req_stall | req_frame_byte, req_frame_end
// rsp_    | out       | rsp_valid/rsp_stall | rsp_drop, rsp_cause, rsp_seen_*_port
// csr_    | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One byte per cycle unless a final byte waits on a stalled rsp_; rsp_valid rises
// after the last beat passes the input register and its verdict the result register.
// Reset (synchronous, active high) clears frame state and loads the default ports.
// A stall on rsp_ holds the pipe only when a final byte waits for the result
// register; other bytes keep flowing into the frame state.
`default_nettype none

`include "assert_macros.svh"

module tcp_port_pair_packet_filter_top (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [tppf_pkg::BYTE_W-1:0]      req_frame_byte,
   input  wire                              req_frame_end,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_drop,
   output logic [tppf_pkg::CAUSE_W-1:0]     rsp_cause,
   output logic [tppf_pkg::PORT_W-1:0]      rsp_seen_src_port,
   output logic [tppf_pkg::PORT_W-1:0]      rsp_seen_dst_port,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [tppf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [tppf_pkg::PORT_W-1:0]      csr_wdata
);
   import tppf_pkg::*;

   logic [PORT_W-1:0]  port_a_ff, port_b_ff;

   logic               in_valid_ff, in_valid_in;
   beat_type           in_beat_ff, in_beat_in;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        ether_type_ff, ether_type_in;
   logic [3:0]         ihl_ff, ihl_in;
   logic [7:0]         proto_ff, proto_in;
   logic [PORT_W-1:0]  src_ff, src_in;
   logic [PORT_W-1:0]  dst_ff, dst_in;

   logic               out_valid_ff, out_valid_in;
   logic               drop_ff, drop_in;
   logic [CAUSE_W-1:0] cause_ff, cause_in;
   logic [PORT_W-1:0]  seen_src_ff, seen_src_in;
   logic [PORT_W-1:0]  seen_dst_ff, seen_dst_in;

   logic               out_free, fire, load;
   logic [COUNT_W-1:0] pos, len, off;
   logic [BYTE_W-1:0]  b;
   logic               fwd, back;

   // csr
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_a_ff <= PORT_A_RESET;
         port_b_ff <= PORT_B_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PORT_A: port_a_ff <= csr_wdata;
            CSR_PORT_B: port_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && (!in_beat_ff.last || out_free);
   assign load      = !in_valid_ff || fire;
   assign req_stall = !load;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_beat_in  = in_beat_ff;
      if (load) begin
         in_valid_in     = req_valid;
         in_beat_in.data = req_frame_byte;
         in_beat_in.last = req_frame_end;
      end
   end

   // parse and verdict
   always_comb begin
      b    = in_beat_ff.data;
      pos  = count_ff;
      ether_type_in = ether_type_ff;
      ihl_in   = ihl_ff;
      proto_in = proto_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      count_in = count_ff;

      if (pos == ETH_TYPE_HI)  ether_type_in[15:8] = b;
      if (pos == ETH_TYPE_LO)  ether_type_in[7:0]  = b;
      if (pos == ETH_HDR_LEN)  ihl_in = b[3:0];
      if (pos == IP_PROTO_POS) proto_in = b;

      off = ETH_HDR_LEN + {1'b0, ihl_in, 2'b00};
      if (pos == off)         src_in[15:8] = b;
      if (pos == off + 7'd1)  src_in[7:0]  = b;
      if (pos == off + 7'd2)  dst_in[15:8] = b;
      if (pos == off + 7'd3)  dst_in[7:0]  = b;

      len = (pos == COUNT_MAX) ? COUNT_MAX : pos + 7'd1;
      count_in = len;

      fwd  = (src_in == port_a_ff) && (dst_in == port_b_ff);
      back = (src_in == port_b_ff) && (dst_in == port_a_ff);

      drop_in     = 1'b0;
      cause_in    = CAUSE_MATCH;
      seen_src_in = '0;
      seen_dst_in = '0;
      if (len < ETH_HDR_LEN) begin
         drop_in  = 1'b1;
         cause_in = CAUSE_SHORT_ETH;
      end else if (ether_type_in != ETHERTYPE_IPV4) begin
         cause_in = CAUSE_NOT_IPV4;
      end else if (len < IP_MIN_END) begin
         drop_in  = 1'b1;
         cause_in = CAUSE_SHORT_IP;
      end else if (proto_in != PROTO_TCP) begin
         cause_in = CAUSE_NOT_TCP;
      end else if (len < off + TCP_HDR_LEN) begin
         drop_in  = 1'b1;
         cause_in = CAUSE_SHORT_TCP;
      end else begin
         seen_src_in = src_in;
         seen_dst_in = dst_in;
         if (!(fwd || back)) begin
            drop_in  = 1'b1;
            cause_in = CAUSE_MISMATCH;
         end
      end

      if (in_beat_ff.last) begin
         count_in      = '0;
         ether_type_in = '0;
         ihl_in        = '0;
         proto_in      = '0;
         src_in        = '0;
         dst_in        = '0;
      end
   end

   assign out_valid_in = (fire && in_beat_ff.last) ? 1'b1 : (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         count_ff      <= '0;
         ether_type_ff <= '0;
         ihl_ff        <= '0;
         proto_ff      <= '0;
         src_ff        <= '0;
         dst_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            count_ff      <= count_in;
            ether_type_ff <= ether_type_in;
            ihl_ff        <= ihl_in;
            proto_ff      <= proto_in;
            src_ff        <= src_in;
            dst_ff        <= dst_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_beat_ff <= in_beat_in;
      if (fire && in_beat_ff.last) begin
         drop_ff     <= drop_in;
         cause_ff    <= cause_in;
         seen_src_ff <= seen_src_in;
         seen_dst_ff <= seen_dst_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_drop          = drop_ff;
   assign rsp_cause         = cause_ff;
   assign rsp_seen_src_port = seen_src_ff;
   assign rsp_seen_dst_port = seen_dst_ff;

   `ASSERT_IMPLY(a_drop_cause, clock, reset, out_valid_ff,
      drop_ff == (cause_ff == CAUSE_SHORT_ETH || cause_ff == CAUSE_SHORT_IP ||
                  cause_ff == CAUSE_SHORT_TCP || cause_ff == CAUSE_MISMATCH),
      "drop flag disagrees with cause")
   `ASSERT_IMPLY(a_ports_zero, clock, reset,
      out_valid_ff && cause_ff != CAUSE_MATCH && cause_ff != CAUSE_MISMATCH,
      seen_src_ff == '0 && seen_dst_ff == '0,
      "ports reported for a frame that never reached them")
   `ASSERT_IMPLY(a_frame_clear, clock, reset,
      !$past(reset) && $past(fire && in_beat_ff.last),
      count_ff == '0 && ihl_ff == '0 && src_ff == '0 && dst_ff == '0,
      "frame state not cleared after final byte")
   `ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall,
      in_valid_ff && in_beat_ff.last && out_valid_ff && rsp_stall,
      "input stalled without a blocked final byte")

endmodule

`default_nettype wire

[bench/tcp_port_pair_packet_filter_top_test.sv]
`timescale 1ns / 1ps

module tcp_port_pair_packet_filter_top_test;
   import tppf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int QUIET_LIMIT  = 10000;
   localparam int HOLD_CYCLES  = 3000;
   localparam int HOLD_AT      = 8;
   localparam int PHASES       = 6;
   localparam int PHASE_BYTES  = 40;
   localparam int PHASE_FRAMES = 1;
   localparam int N_DIRECTED   = 19;

   typedef struct packed {
      logic               drop;
      logic [CAUSE_W-1:0] cause;
      logic [PORT_W-1:0]  src;
      logic [PORT_W-1:0]  dst;
   } verdict_type;

   typedef struct packed {
      logic [7:0]        len;
      logic [15:0]       etype;
      logic [7:0]        verhl;
      logic [7:0]        proto;
      logic [PORT_W-1:0] sport;
      logic [PORT_W-1:0] dport;
      bit                typed;
      verdict_type       want;
   } frame_row_type;

   // typed rows carry the verdict; the rest go through the predictor
   localparam frame_row_type DIRECTED [N_DIRECTED] = '{
      '{8'd1,   ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 16'd0, 16'd0, 1'b1,
        '{1'b1, CAUSE_SHORT_ETH, 16'd0, 16'd0}},
      '{8'd13,  ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 16'd0, 16'd0, 1'b1,
        '{1'b1, CAUSE_SHORT_ETH, 16'd0, 16'd0}},
      '{8'd14,  ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 16'd0, 16'd0, 1'b1,
        '{1'b1, CAUSE_SHORT_IP, 16'd0, 16'd0}},
      '{8'd14,  16'h86DD, 8'h45, PROTO_TCP, 16'd0, 16'd0, 1'b1,
        '{1'b0, CAUSE_NOT_IPV4, 16'd0, 16'd0}},
      '{8'd20,  16'h0008, 8'h45, PROTO_TCP, 16'd0, 16'd0, 1'b1,
        '{1'b0, CAUSE_NOT_IPV4, 16'd0, 16'd0}},
      '{8'd33,  ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 16'd0, 16'd0, 1'b1,
        '{1'b1, CAUSE_SHORT_IP, 16'd0, 16'd0}},
      '{8'd34,  ETHERTYPE_IPV4, 8'h45, 8'h11, 16'd0, 16'd0, 1'b1,
        '{1'b0, CAUSE_NOT_TCP, 16'd0, 16'd0}},
      '{8'd53,  ETHERTYPE_IPV4, 8'h45, PROTO_TCP, PORT_A_RESET, PORT_B_RESET, 1'b1,
        '{1'b1, CAUSE_SHORT_TCP, 16'd0, 16'd0}},
      '{8'd54,  ETHERTYPE_IPV4, 8'h45, PROTO_TCP, PORT_A_RESET, PORT_B_RESET, 1'b1,
        '{1'b0, CAUSE_MATCH, PORT_A_RESET, PORT_B_RESET}},
      '{8'd54,  ETHERTYPE_IPV4, 8'h45, PROTO_TCP, PORT_B_RESET, PORT_A_RESET, 1'b1,
        '{1'b0, CAUSE_MATCH, PORT_B_RESET, PORT_A_RESET}},
      '{8'd54,  ETHERTYPE_IPV4, 8'h45, PROTO_TCP, PORT_A_RESET, PORT_A_RESET, 1'b1,
        '{1'b1, CAUSE_MISMATCH, PORT_A_RESET, PORT_A_RESET}},
      '{8'd54,  ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 16'd0, 16'd0, 1'b1,
        '{1'b1, CAUSE_MISMATCH, 16'd0, 16'd0}},
      '{8'd54,  ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 16'hFFFF, 16'hFFFF, 1'b1,
        '{1'b1, CAUSE_MISMATCH, 16'hFFFF, 16'hFFFF}},
      '{8'd93,  ETHERTYPE_IPV4, 8'h4F, PROTO_TCP, PORT_A_RESET, PORT_B_RESET, 1'b1,
        '{1'b1, CAUSE_SHORT_TCP, 16'd0, 16'd0}},
      '{8'd94,  ETHERTYPE_IPV4, 8'h4F, PROTO_TCP, PORT_A_RESET, PORT_B_RESET, 1'b1,
        '{1'b0, CAUSE_MATCH, PORT_A_RESET, PORT_B_RESET}},
      // count saturation
      '{8'd130, ETHERTYPE_IPV4, 8'h4F, PROTO_TCP, PORT_A_RESET, 16'd81, 1'b0, '0},
      // IHL 0: byte 14 is also the first port byte
      '{8'd40,  ETHERTYPE_IPV4, 8'h40, PROTO_TCP, 16'h4000, PORT_B_RESET, 1'b0, '0},
      // IHL 2: protocol byte doubles as source port low byte
      '{8'd46,  ETHERTYPE_IPV4, 8'h42, PROTO_TCP, 16'h1206, PORT_B_RESET, 1'b0, '0},
      // version nibble ignored
      '{8'd54,  ETHERTYPE_IPV4, 8'h05, PROTO_TCP, PORT_A_RESET, PORT_B_RESET, 1'b0, '0}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_frame_byte;
   logic                 req_frame_end;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_drop;
   logic [CAUSE_W-1:0]   rsp_cause;
   logic [PORT_W-1:0]    rsp_seen_src_port;
   logic [PORT_W-1:0]    rsp_seen_dst_port;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [PORT_W-1:0]    csr_wdata;

   tcp_port_pair_packet_filter_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_frame_byte    (req_frame_byte),
      .req_frame_end     (req_frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drop          (rsp_drop),
      .rsp_cause         (rsp_cause),
      .rsp_seen_src_port (rsp_seen_src_port),
      .rsp_seen_dst_port (rsp_seen_dst_port),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // filter state mirror
   logic [PORT_W-1:0]  allow_a = PORT_A_RESET;
   logic [PORT_W-1:0]  allow_b = PORT_B_RESET;
   logic [COUNT_W-1:0] seen_count;
   logic [15:0]        cur_etype;
   logic [3:0]         cur_ihl;
   logic [7:0]         cur_proto;
   logic [PORT_W-1:0]  cur_sport;
   logic [PORT_W-1:0]  cur_dport;

   verdict_type pending_verdicts[$];
   logic [7:0]  frame_buf[$];

   int errors = 0;
   int beats_sent = 0;
   int verdicts_seen = 0;
   int drops_seen = 0;
   int csr_writes = 0;
   bit [7:0] causes_hit = '0;
   bit send_burst = 1'b0;
   bit recv_burst = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_frame_state();
      seen_count = '0;
      cur_etype  = '0;
      cur_ihl    = '0;
      cur_proto  = '0;
      cur_sport  = '0;
      cur_dport  = '0;
   endfunction

   function automatic bit filter_byte(input logic [7:0] data, input logic is_end,
                                      output verdict_type v);
      int pos;
      int off;
      int len;
      pos = seen_count;
      if (pos == ETH_TYPE_HI) cur_etype[15:8] = data;
      if (pos == ETH_TYPE_LO) cur_etype[7:0] = data;
      if (pos == ETH_HDR_LEN) cur_ihl = data[3:0];
      if (pos == IP_PROTO_POS) cur_proto = data;
      off = ETH_HDR_LEN + 4 * cur_ihl;
      if (pos == off)     cur_sport[15:8] = data;
      if (pos == off + 1) cur_sport[7:0] = data;
      if (pos == off + 2) cur_dport[15:8] = data;
      if (pos == off + 3) cur_dport[7:0] = data;
      len = (pos < COUNT_MAX) ? pos + 1 : COUNT_MAX;
      seen_count = len[COUNT_W-1:0];
      v = '0;
      if (!is_end) return 1'b0;
      if (len < ETH_HDR_LEN) begin
         v.drop = 1'b1;
         v.cause = CAUSE_SHORT_ETH;
      end else if (cur_etype != ETHERTYPE_IPV4) begin
         v.cause = CAUSE_NOT_IPV4;
      end else if (len < IP_MIN_END) begin
         v.drop = 1'b1;
         v.cause = CAUSE_SHORT_IP;
      end else if (cur_proto != PROTO_TCP) begin
         v.cause = CAUSE_NOT_TCP;
      end else if (len < off + TCP_HDR_LEN) begin
         v.drop = 1'b1;
         v.cause = CAUSE_SHORT_TCP;
      end else begin
         v.src = cur_sport;
         v.dst = cur_dport;
         if ((cur_sport == allow_a && cur_dport == allow_b) ||
             (cur_sport == allow_b && cur_dport == allow_a)) begin
            v.cause = CAUSE_MATCH;
         end else begin
            v.drop = 1'b1;
            v.cause = CAUSE_MISMATCH;
         end
      end
      clear_frame_state();
      return 1'b1;
   endfunction

   function automatic void build_frame(input int len, input logic [15:0] etype,
                                       input logic [7:0] verhl, input logic [7:0] proto,
                                       input logic [PORT_W-1:0] sport,
                                       input logic [PORT_W-1:0] dport);
      int off;
      logic [31:0] pair;
      pair = {sport, dport};
      frame_buf.delete();
      for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
      if (len > ETH_TYPE_HI) frame_buf[ETH_TYPE_HI] = etype[15:8];
      if (len > ETH_TYPE_LO) frame_buf[ETH_TYPE_LO] = etype[7:0];
      if (len > ETH_HDR_LEN) frame_buf[ETH_HDR_LEN] = verhl;
      if (len > IP_PROTO_POS) frame_buf[IP_PROTO_POS] = proto;
      off = ETH_HDR_LEN + 4 * verhl[3:0];
      for (int k = 0; k < 4; k++) begin
         if (off + k < len) frame_buf[off + k] = pair[31 - 8 * k -: 8];
      end
   endfunction

   task automatic send_beat(input logic [7:0] data, input logic is_end,
                            input bit typed, input verdict_type want);
      verdict_type v;
      int gap;
      req_valid <= 1'b1;
      req_frame_byte <= data;
      req_frame_end <= is_end;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      if (filter_byte(data, is_end, v)) pending_verdicts.push_back(typed ? want : v);
      if (beats_sent % 50 == 0) send_burst = ($urandom_range(0, 3) == 0);
      gap = send_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_frame(input bit typed, input verdict_type want);
      for (int i = 0; i < frame_buf.size(); i++) begin
         send_beat(frame_buf[i], i == frame_buf.size() - 1, typed, want);
      end
   endtask

   task automatic send_random_frame();
      int kind;
      int ihl;
      int len;
      logic [15:0] etype;
      logic [7:0] proto;
      logic [7:0] verhl;
      logic [PORT_W-1:0] sp;
      logic [PORT_W-1:0] dp;
      kind = $urandom_range(0, 9);
      ihl = 5;
      etype = ETHERTYPE_IPV4;
      proto = PROTO_TCP;
      sp = 16'($urandom);
      dp = 16'($urandom);
      case ($urandom_range(0, 4))
         0: begin
            sp = allow_a;
            dp = allow_b;
         end
         1: begin
            sp = allow_b;
            dp = allow_a;
         end
         2: sp = allow_a;
         3: dp = allow_a;
         default: ;
      endcase
      if ($urandom_range(0, 3) == 0) ihl = $urandom_range(5, 15);
      len = ETH_HDR_LEN + 4 * ihl + TCP_HDR_LEN + $urandom_range(0, 16);
      case (kind)
         5: begin
            ihl = $urandom_range(0, 4);
            len = $urandom_range(34, 60);
         end
         6: len = $urandom_range(1, 40);
         7: begin
            etype = ($urandom_range(0, 3) == 0) ? ETHERTYPE_IPV4 : 16'($urandom);
            proto = 8'($urandom);
            len = $urandom_range(1, 140);
         end
         8: proto = 8'($urandom);
         9: len = ETH_HDR_LEN + 4 * ihl + TCP_HDR_LEN - $urandom_range(1, 6);
         default: ;
      endcase
      if ($urandom_range(0, 19) == 0) len = $urandom_range(128, 180);
      verhl = {($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'h4, 4'(ihl)};
      build_frame(len, etype, verhl, proto, sp, dp);
      send_frame(1'b0, '0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [PORT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
      if (idx == CSR_PORT_A) allow_a = val;
      else if (idx == CSR_PORT_B) allow_b = val;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   initial begin : verdict_checker
      verdict_type want;
      int gap;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         do @(posedge clock); while (rsp_valid !== 1'b1);
         verdicts_seen++;
         causes_hit[rsp_cause] = 1'b1;
         if (rsp_drop) drops_seen++;
         if (pending_verdicts.size() == 0) begin
            $error("unexpected verdict: drop=%0b cause=%0d", rsp_drop, rsp_cause);
            errors++;
         end else begin
            want = pending_verdicts.pop_front();
            check_field("drop", 16'(want.drop), 16'(rsp_drop));
            check_field("cause", 16'(want.cause), 16'(rsp_cause));
            check_field("seen_src_port", want.src, rsp_seen_src_port);
            check_field("seen_dst_port", want.dst, rsp_seen_dst_port);
         end
         if (verdicts_seen % 25 == 0) recv_burst = ($urandom_range(0, 2) == 0);
         gap = recv_burst ? 0 : $urandom_range(0, 15);
         // long back-pressure while the sender keeps pushing
         if (verdicts_seen == HOLD_AT) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset !== 1'b0 || (req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
             (csr_valid === 1'b1 && csr_ready === 1'b1)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int start;
      logic [PORT_W-1:0] na;
      logic [PORT_W-1:0] nb;
      reset = 1'b1;
      req_valid = 1'b0;
      req_frame_byte = '0;
      req_frame_end = 1'b0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_PORT_A;
      csr_wdata = '0;
      clear_frame_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIRECTED; r++) begin
         build_frame(DIRECTED[r].len, DIRECTED[r].etype, DIRECTED[r].verhl,
                     DIRECTED[r].proto, DIRECTED[r].sport, DIRECTED[r].dport);
         send_frame(DIRECTED[r].typed, DIRECTED[r].want);
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         na = 16'($urandom);
         nb = 16'($urandom);
         case (p)
            0: begin
               na = 16'h0000;
               nb = 16'h0000;
            end
            1: begin
               na = 16'hFFFF;
               nb = 16'hFFFF;
            end
            2: begin
               na = 16'h0000;
               nb = 16'hFFFF;
            end
            3: begin
               na = 16'hFFFF;
               nb = 16'h0000;
            end
            5: nb = na;
            default: ;
         endcase
         write_reg(CSR_PORT_A, na);
         write_reg(CSR_PORT_B, nb);
         if (p == 0) write_reg(CSR_UNUSED, 16'hFFFF);
         start = beats_sent;
         for (int n = 0; n < PHASE_FRAMES || beats_sent - start < PHASE_BYTES; n++) begin
            send_random_frame();
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Covered %0d frame bytes, %0d verdicts (%0d dropped), %0d register writes",
               beats_sent, verdicts_seen, drops_seen, csr_writes);
      $display("Verdict causes exercised: %0d of 7, across %0d port settings",
               $countones(causes_hit), PHASES + 1);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
